FILE: src/assert_macros.svh
// Assertion macros shared by the page splitter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: src/fprs_pkg.sv
// Constants and types shared by the flash read page splitter.
package fprs_pkg;

	localparam int DIES             = 16;
	localparam int CHANNELS         = 8;
	localparam int PAGES_PER_DIE    = 1024;
	localparam int SECTORS_PER_PAGE = 4;
	localparam int MAX_SECTORS      = 252;

	localparam int ROW_W    = 32;
	localparam int SLOT_W   = 8;
	localparam int TAG_W    = 9;
	localparam int SECTOR_W = 16;
	localparam int CNT_W    = 8;
	localparam int OFF_W    = 8;
	localparam int MPAGE_W  = 14;
	localparam int CH_W     = 3;
	localparam int WAY_W    = 1;
	localparam int FIP_W    = 2;
	localparam int CHUNK_W  = 3;

	localparam int SPP_W     = $clog2(SECTORS_PER_PAGE);
	localparam int SUM_W     = SECTOR_W + 1;
	localparam int LPN_W     = SUM_W - SPP_W;
	localparam int DIE_W     = $clog2(DIES);
	localparam int DPAGE_W   = LPN_W - DIE_W;
	localparam int WDPAGE_W  = MPAGE_W - DIE_W;
	localparam int MAP_DEPTH = DIES * PAGES_PER_DIE;
	localparam int MAP_AW    = $clog2(MAP_DEPTH);

	localparam logic [ROW_W-1:0] UNMAPPED_ROW = '1;

	typedef struct packed {
		logic              en;
		logic [MAP_AW-1:0] addr;
		logic [ROW_W-1:0]  data;
	} map_wr_t;

endpackage

FILE: src/fprs_map_store.sv
// Page map memory with its clearing sweep after reset and a registered read port.
`include "assert_macros.svh"

module fprs_map_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fprs_pkg::map_wr_t             wr,
	input  logic                          rd_en,
	input  logic [fprs_pkg::MAP_AW-1:0]   rd_addr,
	output logic [fprs_pkg::ROW_W-1:0]    rd_data,
	output logic                          busy
);

	logic [fprs_pkg::ROW_W-1:0]  mem [fprs_pkg::MAP_DEPTH];
	logic [fprs_pkg::MAP_AW-1:0] clr_addr_q;
	logic                        busy_q;
	logic [fprs_pkg::ROW_W-1:0]  rd_data_q;
	logic                        mem_we;
	logic [fprs_pkg::MAP_AW-1:0] mem_waddr;
	logic [fprs_pkg::ROW_W-1:0]  mem_wdata;

	always_comb begin
		if (busy_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = fprs_pkg::UNMAPPED_ROW;
		end else begin
			mem_we    = wr.en;
			mem_waddr = wr.addr;
			mem_wdata = wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == fprs_pkg::MAP_AW'(fprs_pkg::MAP_DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = busy_q;

	`ASSERT_NEVER(a_wr_during_clear, clk, arst_n, busy_q && wr.en, "map write during clear")
	`ASSERT_NEVER(a_rd_wr_overlap, clk, arst_n, rd_en && wr.en, "map read and write together")

endmodule

FILE: src/flash_read_page_splitter_top.sv
// Top level of the flash read page splitter: request decode, chunk sequencer and output register.
// After reset the page map is swept to unmapped, during which no request is taken (spare buffer
// writes are). A map write request is written into the page map memory when it is accepted. A read
// request is accepted in the idle state and then each page chunk passes through a lookup state for
// the map lookup in the page map memory and an emit state to place the result in the output
// register, which waits on any stall on the output. A rejected request places its single result in
// the output register from the reject state once the output register is free.
`include "assert_macros.svh"

module flash_read_page_splitter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// task_slot[7:0], first_sector[23:8], sector_total[31:24], map_page[45:32], map_row[77:46]
	input  logic [79:0] s_tdata,
	// action[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// task_tag[8:0], row_address[40:9], spare_buffer[72:41], channel[75:73], way[76],
	// chunk_offset[84:77], first_in_page[86:85], chunk_sectors[89:87]
	output logic [95:0] m_tdata,
	// mapped[0], rejected[1]
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_LOOK  = 5'b00100,
		S_EMIT  = 5'b01000,
		S_REJ   = 5'b10000
	} state_t;

	state_t state_q;

	logic [fprs_pkg::ROW_W-1:0]    spare_q;
	logic [fprs_pkg::TAG_W-1:0]    tag_q;
	logic [fprs_pkg::SECTOR_W-1:0] first_q;
	logic [fprs_pkg::CNT_W-1:0]    left_q;
	logic [fprs_pkg::OFF_W-1:0]    offset_q;

	logic [fprs_pkg::CH_W-1:0]    ch_s1;
	logic [fprs_pkg::WAY_W-1:0]   way_s1;
	logic [fprs_pkg::OFF_W-1:0]   off_s1;
	logic [fprs_pkg::FIP_W-1:0]   fip_s1;
	logic [fprs_pkg::CHUNK_W-1:0] cnt_s1;
	logic                         in_range_s1;
	logic                         last_s1;

	logic                         out_valid_q;
	logic [fprs_pkg::TAG_W-1:0]   out_tag_q;
	logic [fprs_pkg::ROW_W-1:0]   out_row_q;
	logic [fprs_pkg::ROW_W-1:0]   out_spare_q;
	logic [fprs_pkg::CH_W-1:0]    out_ch_q;
	logic [fprs_pkg::WAY_W-1:0]   out_way_q;
	logic [fprs_pkg::OFF_W-1:0]   out_off_q;
	logic [fprs_pkg::FIP_W-1:0]   out_fip_q;
	logic [fprs_pkg::CHUNK_W-1:0] out_cnt_q;
	logic                         out_mapped_q;
	logic                         out_rej_q;
	logic                         out_last_q;

	logic                          in_acc;
	logic                          out_free;
	logic                          out_load;
	logic [fprs_pkg::SLOT_W-1:0]   in_slot;
	logic [fprs_pkg::SECTOR_W-1:0] in_first;
	logic [fprs_pkg::CNT_W-1:0]    in_total;
	logic [fprs_pkg::MPAGE_W-1:0]  in_page;
	logic [fprs_pkg::ROW_W-1:0]    in_row;

	logic [fprs_pkg::DIE_W-1:0]    wr_die;
	logic [fprs_pkg::WDPAGE_W-1:0] wr_dpage;
	fprs_pkg::map_wr_t             map_wr;

	logic [fprs_pkg::SUM_W-1:0]   look_sector;
	logic [fprs_pkg::LPN_W-1:0]   look_lpn;
	logic [fprs_pkg::FIP_W-1:0]   look_fip;
	logic [fprs_pkg::DIE_W-1:0]   look_die;
	logic [fprs_pkg::DPAGE_W-1:0] look_dpage;
	logic [fprs_pkg::CNT_W:0]     look_fit;
	logic [fprs_pkg::CHUNK_W-1:0] look_cnt;
	logic [fprs_pkg::CNT_W-1:0]   look_left;
	logic                         look_in_range;
	logic [fprs_pkg::MAP_AW-1:0]  look_addr;
	logic                         map_rd_en;
	logic [fprs_pkg::ROW_W-1:0]   map_rd_data;
	logic                         map_busy;
	logic                         emit_mapped;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign out_load  = out_free && ((state_q == S_EMIT) || (state_q == S_REJ));

	assign in_slot  = s_tdata[7:0];
	assign in_first = s_tdata[23:8];
	assign in_total = s_tdata[31:24];
	assign in_page  = s_tdata[45:32];
	assign in_row   = s_tdata[77:46];

	assign wr_die   = fprs_pkg::DIE_W'(in_page % fprs_pkg::DIES);
	assign wr_dpage = fprs_pkg::WDPAGE_W'(in_page / fprs_pkg::DIES);

	always_comb begin
		map_wr.en   = in_acc && !s_tuser && (int'(wr_dpage) < fprs_pkg::PAGES_PER_DIE);
		map_wr.addr = fprs_pkg::MAP_AW'(int'(wr_die) * fprs_pkg::PAGES_PER_DIE + int'(wr_dpage));
		map_wr.data = in_row;
	end

	always_comb begin
		look_sector   = fprs_pkg::SUM_W'(first_q) + fprs_pkg::SUM_W'(offset_q);
		look_fip      = look_sector[fprs_pkg::SPP_W-1:0];
		look_lpn      = look_sector[fprs_pkg::SUM_W-1:fprs_pkg::SPP_W];
		look_die      = fprs_pkg::DIE_W'(look_lpn % fprs_pkg::DIES);
		look_dpage    = fprs_pkg::DPAGE_W'(look_lpn / fprs_pkg::DIES);
		look_fit      = {1'b0, left_q} + (fprs_pkg::CNT_W + 1)'(look_fip);
		if (look_fit > (fprs_pkg::CNT_W + 1)'(fprs_pkg::SECTORS_PER_PAGE)) begin
			look_cnt = fprs_pkg::CHUNK_W'(fprs_pkg::SECTORS_PER_PAGE)
				- fprs_pkg::CHUNK_W'(look_fip);
		end else begin
			look_cnt = fprs_pkg::CHUNK_W'(left_q);
		end
		look_left     = left_q - fprs_pkg::CNT_W'(look_cnt);
		look_in_range = int'(look_dpage) < fprs_pkg::PAGES_PER_DIE;
		look_addr     = fprs_pkg::MAP_AW'(int'(look_die) * fprs_pkg::PAGES_PER_DIE
			+ int'(look_dpage));
	end

	assign map_rd_en   = (state_q == S_LOOK) && look_in_range;
	assign emit_mapped = in_range_s1 && (map_rd_data != fprs_pkg::UNMAPPED_ROW);

	fprs_map_store u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (map_wr),
		.rd_en   (map_rd_en),
		.rd_addr (look_addr),
		.rd_data (map_rd_data),
		.busy    (map_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			spare_q     <= '0;
			left_q      <= '0;
			offset_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				spare_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (!map_busy) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc && s_tuser) begin
						left_q   <= in_total;
						offset_q <= '0;
						if (in_total > fprs_pkg::CNT_W'(fprs_pkg::MAX_SECTORS)) begin
							state_q <= S_REJ;
						end else if (in_total != '0) begin
							state_q <= S_LOOK;
						end
					end
				end
				S_LOOK: begin
					left_q   <= look_left;
					offset_q <= offset_q + fprs_pkg::OFF_W'(look_cnt);
					state_q  <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= last_s1 ? S_IDLE : S_LOOK;
					end
				end
				S_REJ: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && s_tuser) begin
			tag_q   <= fprs_pkg::TAG_W'(in_slot) + 1'b1;
			first_q <= in_first;
		end
		if (state_q == S_LOOK) begin
			ch_s1       <= fprs_pkg::CH_W'(look_die % fprs_pkg::CHANNELS);
			way_s1      <= fprs_pkg::WAY_W'(look_die / fprs_pkg::CHANNELS);
			off_s1      <= offset_q;
			fip_s1      <= look_fip;
			cnt_s1      <= look_cnt;
			in_range_s1 <= look_in_range;
			last_s1     <= (look_left == '0);
		end
		if (state_q == S_EMIT && out_free) begin
			out_tag_q    <= tag_q;
			out_row_q    <= emit_mapped ? map_rd_data : '0;
			out_spare_q  <= emit_mapped ? spare_q : '0;
			out_ch_q     <= ch_s1;
			out_way_q    <= way_s1;
			out_off_q    <= off_s1;
			out_fip_q    <= fip_s1;
			out_cnt_q    <= cnt_s1;
			out_mapped_q <= emit_mapped;
			out_rej_q    <= 1'b0;
			out_last_q   <= last_s1;
		end else if (state_q == S_REJ && out_free) begin
			out_tag_q    <= tag_q;
			out_row_q    <= '0;
			out_spare_q  <= '0;
			out_ch_q     <= '0;
			out_way_q    <= '0;
			out_off_q    <= '0;
			out_fip_q    <= '0;
			out_cnt_q    <= '0;
			out_mapped_q <= 1'b0;
			out_rej_q    <= 1'b1;
			out_last_q   <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_cnt_q, out_fip_q, out_off_q, out_way_q, out_ch_q,
		out_spare_q, out_row_q, out_tag_q};
	assign m_tuser  = {out_rej_q, out_mapped_q};
	assign m_tlast  = out_last_q;

	`ASSERT_IMPLIES(a_look_has_work, clk, arst_n, state_q == S_LOOK, left_q != '0, "empty lookup")
	`ASSERT_NEVER(a_accept_in_clear, clk, arst_n, in_acc && map_busy, "request during clear")

endmodule
